### hw/rtl/timed_debounce_with_persistence_unit_defines.svh
`ifndef TIMED_DEBOUNCE_WITH_PERSISTENCE_UNIT_DEFINES_SVH
`define TIMED_DEBOUNCE_WITH_PERSISTENCE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TDPU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TDPU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/tdpu_pkg.sv
`timescale 1ns / 1ps

package tdpu_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned CFG_IDX_W = 1;

    localparam int unsigned IN_FIELDS_W  = 1 + TIME_W;
    localparam int unsigned IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned OUT_FIELDS_W = 3 + COUNT_W;
    localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [CFG_W-1:0] WINDOW_RESET  = 16'd50;
    localparam logic [CFG_W-1:0] PERSIST_RESET = 16'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW  = 1'b0,
        CFG_PERSIST = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [COUNT_W-1:0] confirm_count;
        logic               alert_pending;
        logic               candidate_level;
        logic               conditioned_level;
    } result_t;

endpackage

### hw/rtl/timed_debounce_with_persistence_unit.sv
`timescale 1ns / 1ps

// Time-window debounce with a confirmation count.
// s_* carries one request per sample: raw level and a wrapping ms timestamp.
// m_* returns one result per sample: conditioned level, candidate level,
// alert flag and confirmation count after that sample.
// cfg_* writes the debounce window (index 0) and the persistence limit
// (index 1); cfg_ready is always high, writes are meant for an idle block.
// From s_* acceptance to m_tvalid, the accepting edge loads the input register,
// then the state update is loaded into the result register once that register is free.
// Throughput is one sample per cycle while m_tready stays high, set by the
// combinational state update loop (subtract, compare, count).
// A new sample is taken while a finished result waits on m_*; when the
// receiver stalls, both stages fill and s_tready drops until m_tready returns.
// Reset clears both stages, the debounce state (candidate, start time,
// count, conditioned level all zero) and loads window 50 ms, limit 3.
module timed_debounce_with_persistence_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] level, [32:1] now_ms, rest zero
    input  logic [tdpu_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] conditioned_level, [1] candidate_level, [2] alert_pending,
    // [18:3] confirm_count, rest zero
    output logic [tdpu_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tdpu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tdpu_pkg::CFG_W-1:0]          cfg_data
);

    logic [tdpu_pkg::CFG_W-1:0]    window_reg;
    logic [tdpu_pkg::CFG_W-1:0]    persist_reg;

    logic                          in_valid_reg;
    logic                          level_reg;
    logic [tdpu_pkg::TIME_W-1:0]   now_reg;

    logic                          candidate_reg;
    logic                          candidate_next;
    logic [tdpu_pkg::TIME_W-1:0]   since_reg;
    logic [tdpu_pkg::TIME_W-1:0]   since_next;
    logic [tdpu_pkg::COUNT_W-1:0]  count_reg;
    logic [tdpu_pkg::COUNT_W-1:0]  count_next;
    logic                          conditioned_reg;
    logic                          conditioned_next;

    logic                          out_valid_reg;
    tdpu_pkg::result_t             result_reg;
    tdpu_pkg::result_t             result_next;

    logic                          advance;
    logic                          changed;
    logic [tdpu_pkg::COUNT_W-1:0]  count_base;
    logic [tdpu_pkg::COUNT_W-1:0]  count_inc;
    logic [tdpu_pkg::TIME_W-1:0]   elapsed;
    logic                          window_met;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(tdpu_pkg::OUT_DATA_W - tdpu_pkg::OUT_FIELDS_W){1'b0}}, result_reg};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= tdpu_pkg::WINDOW_RESET;
            persist_reg <= tdpu_pkg::PERSIST_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (tdpu_pkg::cfg_idx_t'(cfg_index))
                tdpu_pkg::CFG_WINDOW:  window_reg  <= cfg_data;
                tdpu_pkg::CFG_PERSIST: persist_reg <= cfg_data;
                default:               window_reg  <= window_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            level_reg <= s_tdata[0];
            now_reg   <= s_tdata[tdpu_pkg::TIME_W:1];
        end
    end

    // state update for the sample in the input register
    always_comb
    begin
        changed          = (level_reg != candidate_reg);
        candidate_next   = level_reg;
        since_next       = changed ? now_reg : since_reg;
        count_base       = changed ? '0 : count_reg;
        elapsed          = now_reg - since_next;
        window_met       = (elapsed >= {{(tdpu_pkg::TIME_W - tdpu_pkg::CFG_W){1'b0}}, window_reg});
        count_inc        = (count_base < persist_reg) ? count_base + 1'b1 : count_base;
        conditioned_next = conditioned_reg;
        count_next       = count_base;
        if (candidate_next == conditioned_reg)
        begin
            count_next = '0;
        end
        else if (window_met)
        begin
            if (count_inc >= persist_reg)
            begin
                conditioned_next = candidate_next;
                count_next       = '0;
            end
            else
            begin
                count_next = count_inc;
            end
        end
        result_next.conditioned_level = conditioned_next;
        result_next.candidate_level   = candidate_next;
        result_next.alert_pending     = (candidate_next != conditioned_next);
        result_next.confirm_count     = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            candidate_reg   <= 1'b0;
            since_reg       <= '0;
            count_reg       <= '0;
            conditioned_reg <= 1'b0;
        end
        else if (advance)
        begin
            candidate_reg   <= candidate_next;
            since_reg       <= since_next;
            count_reg       <= count_next;
            conditioned_reg <= conditioned_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

endmodule

### hw/rtl/tdpu_checker.sv
`timescale 1ns / 1ps
`include "timed_debounce_with_persistence_unit_defines.svh"

module tdpu_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [tdpu_pkg::IN_DATA_W-1:0]      s_tdata,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [tdpu_pkg::OUT_DATA_W-1:0]     m_tdata,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [tdpu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input logic [tdpu_pkg::CFG_W-1:0]          cfg_data
);

    // a stalled result holds
    `TDPU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // alert is exactly candidate against conditioned level
    `TDPU_ASSERT_NOW(a_alert_match, m_tvalid, m_tdata[2] == (m_tdata[0] != m_tdata[1]), "alert does not match levels")

    // count is cleared whenever no change is pending
    `TDPU_ASSERT_NOW(a_count_idle, m_tvalid && !m_tdata[2], m_tdata[18:3] == '0, "count not cleared without alert")

    // input side only backs up behind a waiting result
    `TDPU_ASSERT_NOW(a_backpressure, !s_tready, m_tvalid && !m_tready, "input stalled with output free")

endmodule

bind timed_debounce_with_persistence_unit tdpu_checker u_tdpu_checker (.*);

### sim/timed_debounce_with_persistence_unit_test.sv
`timescale 1ns / 1ps

module timed_debounce_with_persistence_unit_test;

    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct {
        logic        level;
        logic [31:0] now_ms;
    } sample_t;

    logic                             clk;
    logic                             rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [tdpu_pkg::IN_DATA_W-1:0]   s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [tdpu_pkg::OUT_DATA_W-1:0]  m_tdata;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [tdpu_pkg::CFG_IDX_W-1:0]   cfg_index = tdpu_pkg::CFG_WINDOW;
    logic [tdpu_pkg::CFG_W-1:0]       cfg_data = '0;

    // model of the debounce state and its registers
    logic [tdpu_pkg::CFG_W-1:0]   window_ms = tdpu_pkg::WINDOW_RESET;
    logic [tdpu_pkg::CFG_W-1:0]   persist_limit = tdpu_pkg::PERSIST_RESET;
    logic                         cand_level = 1'b0;
    logic [tdpu_pkg::TIME_W-1:0]  cand_since = '0;
    logic [tdpu_pkg::COUNT_W-1:0] confirms = '0;
    logic                         cond_level = 1'b0;

    sample_t sample_queue[$];
    tdpu_pkg::result_t predicted_levels[$];

    int unsigned queued_count = 0;
    int unsigned accepted_count = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    bit          in_fire = 1'b0;
    int          send_gap = 0;
    int          stall_left = 0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;
    sample_t     next_sample;
    tdpu_pkg::result_t want;
    tdpu_pkg::result_t got;

    timed_debounce_with_persistence_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic tdpu_pkg::result_t debounce_step(input logic lvl,
                                                        input logic [tdpu_pkg::TIME_W-1:0] now_ms);
        logic [tdpu_pkg::TIME_W-1:0] elapsed;
        tdpu_pkg::result_t           r;
        if (lvl != cand_level)
        begin
            cand_level = lvl;
            cand_since = now_ms;
            confirms   = '0;
        end
        elapsed = now_ms - cand_since;
        if (cand_level == cond_level)
        begin
            confirms = '0;
        end
        else if (elapsed >= {16'd0, window_ms})
        begin
            if (confirms < persist_limit)
            begin
                confirms = confirms + 1'b1;
            end
            if (confirms >= persist_limit)
            begin
                cond_level = cand_level;
                confirms   = '0;
            end
        end
        r.conditioned_level = cond_level;
        r.candidate_level   = cand_level;
        r.alert_pending     = (cand_level != cond_level);
        r.confirm_count     = confirms;
        return r;
    endfunction

    // mostly short gaps, a few long ones, none while calm
    function automatic int gap_len(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
        begin
            return 0;
        end
        else if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 25);
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // sender
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (s_tvalid && !in_fire)
        begin
            // request still waiting
        end
        else if (send_gap != 0)
        begin
            send_gap--;
            s_tvalid <= 1'b0;
        end
        else if (sample_queue.size() != 0)
        begin
            next_sample = sample_queue.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= {{(tdpu_pkg::IN_DATA_W-tdpu_pkg::IN_FIELDS_W){1'b0}},
                         next_sample.now_ms, next_sample.level};
            if ($urandom_range(0, 49) == 0)
            begin
                send_calm = !send_calm;
            end
            send_gap = gap_len(send_calm);
        end
        else
        begin
            s_tvalid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 49) == 0)
            begin
                recv_calm = !recv_calm;
            end
            stall_left = gap_len(recv_calm);
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
            else
            begin
                in_fire = s_tvalid && s_tready;
                if (m_tvalid && m_tready)
                begin
                    if (predicted_levels.size() == 0)
                    begin
                        $error("result with no request outstanding");
                        fail_count++;
                    end
                    else
                    begin
                        want = predicted_levels.pop_front();
                        got  = tdpu_pkg::result_t'(m_tdata[tdpu_pkg::OUT_FIELDS_W-1:0]);
                        check_field("conditioned_level", want.conditioned_level,
                                    got.conditioned_level);
                        check_field("candidate_level", want.candidate_level,
                                    got.candidate_level);
                        check_field("alert_pending", want.alert_pending,
                                    got.alert_pending);
                        check_field("confirm_count", want.confirm_count,
                                    got.confirm_count);
                    end
                end
                if (in_fire)
                begin
                    predicted_levels.push_back(debounce_step(s_tdata[0],
                                                             s_tdata[tdpu_pkg::TIME_W:1]));
                    accepted_count++;
                end
            end
        end
    end

    task automatic push_sample(input logic lvl, input logic [tdpu_pkg::TIME_W-1:0] now_ms);
        sample_t smp;
        smp.level  = lvl;
        smp.now_ms = now_ms;
        sample_queue.push_back(smp);
        queued_count++;
    endtask

    task automatic write_reg(input tdpu_pkg::cfg_idx_t idx,
                             input logic [tdpu_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            tdpu_pkg::CFG_WINDOW:  window_ms = val;
            tdpu_pkg::CFG_PERSIST: persist_limit = val;
            default:               ;
        endcase
    endtask

    task automatic set_config(input logic [tdpu_pkg::CFG_W-1:0] win,
                              input logic [tdpu_pkg::CFG_W-1:0] lim);
        write_reg(tdpu_pkg::CFG_WINDOW, win);
        write_reg(tdpu_pkg::CFG_PERSIST, lim);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (accepted_count != queued_count || predicted_levels.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // bounce bursts followed by steady holds, with some random noise
    task automatic random_phase(input int n, input logic [tdpu_pkg::TIME_W-1:0] start_ms,
                                input int win);
        logic [tdpu_pkg::TIME_W-1:0] t;
        logic                        target;
        int                          made;
        int                          bounces;
        int                          hold;
        t = start_ms;
        made = 0;
        while (made < n)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                push_sample(1'($urandom_range(0, 1)), $urandom);
                made++;
            end
            else
            begin
                target  = 1'($urandom_range(0, 1));
                bounces = $urandom_range(0, 4);
                for (int i = 0; i < bounces; i++)
                begin
                    t = t + $urandom_range(0, (win >> 3) + 1);
                    push_sample(target ^ ((bounces - i) % 2 == 1), t);
                    made++;
                end
                hold = $urandom_range(1, 12);
                for (int i = 0; i < hold; i++)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        t = t + win + $urandom_range(0, 3);
                    end
                    else
                    begin
                        t = t + $urandom_range(0, (win >> 2) + 2);
                    end
                    push_sample(target, t);
                    made++;
                end
            end
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // reset settings: window, commit after three confirmations, wrap
        push_sample(1'b0, 32'd0);
        push_sample(1'b1, 32'd10);
        push_sample(1'b1, 32'd59);
        push_sample(1'b1, 32'd60);
        push_sample(1'b1, 32'd61);
        push_sample(1'b1, 32'd62);
        push_sample(1'b1, 32'd70);
        push_sample(1'b0, 32'd100);
        push_sample(1'b1, 32'd101);
        push_sample(1'b0, 32'hFFFF_FFF0);
        push_sample(1'b0, 32'h0000_0030);
        push_sample(1'b0, 32'hFFFF_FFE0);
        push_sample(1'b0, 32'hFFFF_FFFF);
        wait_drained();

        // zero window, zero persistence
        set_config(16'd0, 16'd0);
        push_sample(1'b1, 32'd1234);
        push_sample(1'b0, 32'd5);
        wait_drained();

        // count up, then lower the limit beneath it
        set_config(16'd0, 16'd5);
        push_sample(1'b1, 32'd7);
        push_sample(1'b1, 32'd7);
        push_sample(1'b1, 32'd8);
        wait_drained();
        set_config(16'd0, 16'd1);
        push_sample(1'b1, 32'd9);
        wait_drained();

        set_config(16'd50, 16'd3);
        random_phase(182, $urandom, 50);
        set_config(16'd0, 16'd0);
        random_phase(182, $urandom, 0);
        set_config(16'd0, 16'd1);
        random_phase(182, 32'hFFFF_FF00, 0);
        set_config(16'd1, 16'd0);
        random_phase(182, $urandom, 1);
        set_config(16'hFFFF, 16'hFFFF);
        random_phase(182, $urandom, 65535);
        set_config(16'hFFFF, 16'd2);
        random_phase(182, 32'hFFF0_0000, 65535);
        set_config(16'($urandom_range(0, 300)), 16'($urandom_range(0, 6)));
        random_phase(182, $urandom, int'(window_ms));
        set_config(16'($urandom_range(0, 300)), 16'($urandom_range(0, 6)));
        random_phase(182, $urandom, int'(window_ms));

        repeat (8) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
